FILE: rtl/polyline_point_editor_assert.svh
// assertion macros shared by the polyline point editor modules
// expects clk_i and rst_ni in the scope of each use
`ifndef POLYLINE_POINT_EDITOR_ASSERT_SVH
`define POLYLINE_POINT_EDITOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppe_pkg.sv
// shared types, sizes and helpers for the polyline point editor
// no dependencies
`timescale 1ns / 1ps

package ppe_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordBits = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int DiffW     = CoordBits + 1;
  localparam int SqW       = 2 * DiffW + 2;
  localparam int MulAW     = 2 * SqW;
  localparam int MulBW     = SqW;
  localparam int ProdW     = MulAW + MulBW;
  localparam int PointW    = 3 * CoordBits;
  localparam int StepW     = 4;
  localparam int TouchW    = 6;
  localparam int CountW    = 7;
  localparam int PosW      = 16;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;

  typedef enum logic [2:0] {
    OpDelete  = 3'd0,
    OpMove    = 3'd1,
    OpPrepend = 3'd2,
    OpAppend  = 3'd3,
    OpInsert  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StatDone  = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  function automatic coord_t sext_coord(logic [PosW-1:0] v);
    return coord_t'(v[CoordBits-1:0]);
  endfunction

  function automatic logic [DiffW-1:0] mag_diff(diff_t v);
    return v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
  endfunction

endpackage

FILE: rtl/ppe_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module ppe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ppe_mul.sv
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on ppe_pkg and polyline_point_editor_assert.svh
`timescale 1ns / 1ps
`include "polyline_point_editor_assert.svh"

module ppe_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppe_pkg::MulAW-1:0] a_i,
  input  logic [ppe_pkg::MulBW-1:0] b_i,
  output logic                      done_o,
  output logic [ppe_pkg::ProdW-1:0] prod_o
);
  import ppe_pkg::*;

  localparam int CycW = $clog2(MulBW + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CycW-1:0]  cyc_q, cyc_d;
  logic [MulAW-1:0] a_q, a_d;
  logic [MulAW-1:0] hi_q, hi_d;
  logic [MulBW-1:0] lo_q, lo_d;
  logic [MulAW:0]   sum;

  // low product bits shift into the multiplier register as it empties
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cyc_d  = cyc_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      run_d = 1'b1;
      cyc_d = '0;
      a_d   = a_i;
      hi_d  = '0;
      lo_d  = b_i;
    end else if (run_q) begin
      hi_d  = sum[MulAW:1];
      lo_d  = {sum[0], lo_q[MulBW-1:1]};
      cyc_d = cyc_q + 1'b1;
      if (cyc_q == CycW'(MulBW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cyc_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cyc_q  <= cyc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

  `PPE_ASSERT_SAME(a_start_idle, start_i, !run_q, "multiply started while running")
  `PPE_ASSERT_SAME(a_done_idle, done_o, !run_q, "done raised while still running")
  `PPE_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "done held for two cycles")

endmodule

FILE: rtl/polyline_point_editor.sv
// polyline point editor top level: sequencer, point table and result register
// depends on ppe_pkg, ppe_ram, ppe_mul and polyline_point_editor_assert.svh
`timescale 1ns / 1ps
`include "polyline_point_editor_assert.svh"

// Edits an ordered path of up to 64 points, one command at a time. A command is
// taken when start is high and busy is low; busy stays high until the result is
// formed, and the result then shows on status_o, touched_index_o and
// point_count_o for exactly one cycle with valid_o high. There is no back
// pressure on results. All distance work runs through one bit-serial
// multiplier. The nearest point scan for delete or move takes three products per
// point, and delete then shifts the later entries down; the segment scan for
// insert takes fourteen products per segment, three for a zero-length one, and
// insert then shifts the later entries up; prepend shifts every entry up. The
// single-port-write point table sets the shift cost.

module polyline_point_editor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 op_i,
  input  logic signed [15:0]         pos_x_i,
  input  logic signed [15:0]         pos_y_i,
  input  logic signed [15:0]         pos_z_i,
  output logic                       valid_o,
  output logic [1:0]                 status_o,
  output logic [ppe_pkg::TouchW-1:0] touched_index_o,
  output logic [ppe_pkg::CountW-1:0] point_count_o
);
  import ppe_pkg::*;

  typedef enum logic [10:0] {
    StIdle   = 11'b000_0000_0001,
    StRdA    = 11'b000_0000_0010,
    StLatA   = 11'b000_0000_0100,
    StLatB   = 11'b000_0000_1000,
    StMStart = 11'b000_0001_0000,
    StMWait  = 11'b000_0010_0000,
    StInsChk = 11'b000_0100_0000,
    StInsWr  = 11'b000_1000_0000,
    StDelChk = 11'b001_0000_0000,
    StDelWr  = 11'b010_0000_0000,
    StFin    = 11'b100_0000_0000
  } state_e;

  // multiply schedule, one code per product
  localparam logic [StepW-1:0] StepSq0  = 4'd0;
  localparam logic [StepW-1:0] StepSq1  = 4'd1;
  localparam logic [StepW-1:0] StepSq2  = 4'd2;
  localparam logic [StepW-1:0] StepCxA  = 4'd3;
  localparam logic [StepW-1:0] StepCxB  = 4'd4;
  localparam logic [StepW-1:0] StepCxSq = 4'd5;
  localparam logic [StepW-1:0] StepCyA  = 4'd6;
  localparam logic [StepW-1:0] StepCyB  = 4'd7;
  localparam logic [StepW-1:0] StepCySq = 4'd8;
  localparam logic [StepW-1:0] StepCzA  = 4'd9;
  localparam logic [StepW-1:0] StepCzB  = 4'd10;
  localparam logic [StepW-1:0] StepCzSq = 4'd11;
  localparam logic [StepW-1:0] StepLhs  = 4'd12;
  localparam logic [StepW-1:0] StepRhs  = 4'd13;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  status_e           stat_q, stat_d;
  coord_t            q_q [3];
  coord_t            q_d [3];
  coord_t            pa_q [3];
  coord_t            pa_d [3];
  coord_t            pb_q [3];
  coord_t            pb_d [3];
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   at_q, at_d;
  logic [CntW-1:0]   best_q, best_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              seg_q, seg_d;
  logic              have_q, have_d;
  logic [SqW-1:0]    lacc_q, lacc_d;
  logic [MulAW-1:0]  cacc_q, cacc_d;
  logic signed [SqW-1:0] t_q, t_d;
  logic signed [SqW-1:0] cr_q, cr_d;
  logic [ProdW-1:0]  lhs_q, lhs_d;
  // best squared length of the nearest segment, or best squared distance in point scans
  logic [SqW-1:0]    bl_q, bl_d;
  logic [MulAW-1:0]  bc_q, bc_d;
  logic              valid_q, valid_d;
  logic [1:0]        ostat_q, ostat_d;
  logic [TouchW-1:0] otouch_q, otouch_d;
  logic [CountW-1:0] ocount_q, ocount_d;

  diff_t             w_v [3];
  diff_t             l_v [3];
  diff_t             sq_v [3];
  logic [SqW-1:0]    cr_mag;
  logic [MulAW-1:0]  op_a;
  logic [MulBW-1:0]  op_b;
  logic              neg;
  logic              mul_start;
  logic              mul_done;
  logic [ProdW-1:0]  mul_prod;
  logic signed [SqW-1:0] sprod;
  logic [SqW-1:0]    lsum;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [PointW-1:0] ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [PointW-1:0] ram_rdata;

  ppe_ram #(
    .Width(PointW),
    .Depth(MaxPoints)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ppe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_v[k]  = diff_t'(pa_q[k]) - diff_t'(q_q[k]);
      l_v[k]  = diff_t'(pb_q[k]) - diff_t'(pa_q[k]);
      sq_v[k] = seg_q ? l_v[k] : w_v[k];
    end
    cr_mag = cr_q[SqW-1] ? SqW'(-cr_q) : SqW'(cr_q);
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    neg  = 1'b0;
    unique case (step_q)
      StepSq0: begin
        op_a = MulAW'(mag_diff(sq_v[0]));
        op_b = MulBW'(mag_diff(sq_v[0]));
      end
      StepSq1: begin
        op_a = MulAW'(mag_diff(sq_v[1]));
        op_b = MulBW'(mag_diff(sq_v[1]));
      end
      StepSq2: begin
        op_a = MulAW'(mag_diff(sq_v[2]));
        op_b = MulBW'(mag_diff(sq_v[2]));
      end
      StepCxA: begin
        op_a = MulAW'(mag_diff(l_v[1]));
        op_b = MulBW'(mag_diff(w_v[2]));
        neg  = l_v[1][DiffW-1] ^ w_v[2][DiffW-1];
      end
      StepCxB: begin
        op_a = MulAW'(mag_diff(l_v[2]));
        op_b = MulBW'(mag_diff(w_v[1]));
        neg  = l_v[2][DiffW-1] ^ w_v[1][DiffW-1];
      end
      StepCyA: begin
        op_a = MulAW'(mag_diff(l_v[2]));
        op_b = MulBW'(mag_diff(w_v[0]));
        neg  = l_v[2][DiffW-1] ^ w_v[0][DiffW-1];
      end
      StepCyB: begin
        op_a = MulAW'(mag_diff(l_v[0]));
        op_b = MulBW'(mag_diff(w_v[2]));
        neg  = l_v[0][DiffW-1] ^ w_v[2][DiffW-1];
      end
      StepCzA: begin
        op_a = MulAW'(mag_diff(l_v[0]));
        op_b = MulBW'(mag_diff(w_v[1]));
        neg  = l_v[0][DiffW-1] ^ w_v[1][DiffW-1];
      end
      StepCzB: begin
        op_a = MulAW'(mag_diff(l_v[1]));
        op_b = MulBW'(mag_diff(w_v[0]));
        neg  = l_v[1][DiffW-1] ^ w_v[0][DiffW-1];
      end
      StepCxSq, StepCySq, StepCzSq: begin
        op_a = MulAW'(cr_mag);
        op_b = cr_mag;
      end
      StepLhs: begin
        op_a = cacc_q;
        op_b = bl_q;
      end
      StepRhs: begin
        op_a = bc_q;
        op_b = lacc_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sprod = neg ? -$signed(mul_prod[SqW-1:0]) : $signed(mul_prod[SqW-1:0]);
  assign lsum  = lacc_q + mul_prod[SqW-1:0];

  always_comb begin
    logic            pt_better;
    logic            seg_better;
    logic [CntW-1:0] next_idx;
    logic [CntW-1:0] pick;
    logic            pick_have;

    state_d   = state_q;
    op_d      = op_q;
    stat_d    = stat_q;
    q_d       = q_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    at_d      = at_q;
    best_d    = best_q;
    step_d    = step_q;
    seg_d     = seg_q;
    have_d    = have_q;
    lacc_d    = lacc_q;
    cacc_d    = cacc_q;
    t_d       = t_q;
    cr_d      = cr_q;
    lhs_d     = lhs_q;
    bl_d      = bl_q;
    bc_d      = bc_q;
    valid_d   = 1'b0;
    ostat_d   = ostat_q;
    otouch_d  = otouch_q;
    ocount_d  = ocount_q;
    mul_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IdxW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[IdxW-1:0];
    pt_better  = (idx_q == '0) || (lsum < bl_q);
    seg_better = !have_q || (lhs_q < mul_prod);
    next_idx   = idx_q + 1'b1;
    pick       = best_q;
    pick_have  = have_q;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          op_d   = op_e'(op_i);
          q_d[0] = sext_coord(pos_x_i);
          q_d[1] = sext_coord(pos_y_i);
          q_d[2] = sext_coord(pos_z_i);
          stat_d = StatDone;
          at_d   = '0;
          idx_d  = '0;
          have_d = 1'b0;
          seg_d  = 1'b0;
          priority case (op_i)
            OpDelete, OpMove: begin
              if (cnt_q == '0) begin
                stat_d  = StatEmpty;
                state_d = StFin;
              end else begin
                state_d = StRdA;
              end
            end
            OpPrepend, OpAppend, OpInsert: begin
              if (cnt_q == CntW'(MaxPoints)) begin
                stat_d  = StatFull;
                state_d = StFin;
              end else if (op_i == OpPrepend) begin
                idx_d   = cnt_q;
                state_d = StInsChk;
              end else if (op_i == OpAppend || cnt_q < CntW'(2)) begin
                at_d    = cnt_q;
                idx_d   = cnt_q;
                state_d = StInsChk;
              end else begin
                seg_d   = 1'b1;
                state_d = StRdA;
              end
            end
            default: state_d = StFin;
          endcase
        end
      end

      StRdA: begin
        lacc_d  = '0;
        cacc_d  = '0;
        step_d  = StepSq0;
        state_d = StLatA;
      end

      StLatA: begin
        for (int k = 0; k < 3; k++) begin
          pa_d[k] = coord_t'(ram_rdata[k*CoordBits +: CoordBits]);
        end
        ram_raddr = next_idx[IdxW-1:0];
        state_d   = seg_q ? StLatB : StMStart;
      end

      StLatB: begin
        for (int k = 0; k < 3; k++) begin
          pb_d[k] = coord_t'(ram_rdata[k*CoordBits +: CoordBits]);
        end
        state_d = StMStart;
      end

      StMStart: begin
        mul_start = 1'b1;
        state_d   = StMWait;
      end

      StMWait: begin
        if (mul_done) begin
          state_d = StMStart;
          step_d  = step_q + 1'b1;
          unique case (step_q)
            StepSq0, StepSq1: lacc_d = lsum;
            StepSq2: begin
              lacc_d = lsum;
              if (!seg_q) begin
                // nearest point scan, lowest index wins ties
                if (pt_better) begin
                  bl_d   = lsum;
                  best_d = idx_q;
                  pick   = idx_q;
                end
                idx_d   = next_idx;
                state_d = StRdA;
                if (next_idx == cnt_q) begin
                  at_d  = pick;
                  idx_d = pick;
                  state_d = (op_q == OpDelete) ? StDelChk : StInsChk;
                end
              end else if (lsum == '0) begin
                // zero-length segment is skipped
                idx_d   = next_idx;
                state_d = StRdA;
                if (next_idx + 1'b1 == cnt_q) begin
                  at_d    = have_q ? best_q : cnt_q;
                  idx_d   = cnt_q;
                  state_d = StInsChk;
                end
              end
            end
            StepCxA, StepCyA, StepCzA: t_d = sprod;
            StepCxB, StepCyB, StepCzB: cr_d = t_q - sprod;
            StepCxSq, StepCySq, StepCzSq: cacc_d = cacc_q + mul_prod[MulAW-1:0];
            StepLhs: lhs_d = mul_prod;
            StepRhs: begin
              if (seg_better) begin
                have_d    = 1'b1;
                bc_d      = cacc_q;
                bl_d      = lacc_q;
                best_d    = next_idx;
                pick      = next_idx;
                pick_have = 1'b1;
              end
              idx_d   = next_idx;
              state_d = StRdA;
              if (next_idx + 1'b1 == cnt_q) begin
                at_d    = pick_have ? pick : cnt_q;
                idx_d   = cnt_q;
                state_d = StInsChk;
              end
            end
            default: state_d = StFin;
          endcase
        end
      end

      StInsChk: begin
        if (idx_q > at_q) begin
          ram_raddr = IdxW'(idx_q - 1'b1);
          state_d   = StInsWr;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = at_q[IdxW-1:0];
          ram_wdata = {q_q[2], q_q[1], q_q[0]};
          if (op_q != OpMove) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = StFin;
        end
      end

      StInsWr: begin
        ram_we  = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = StInsChk;
      end

      StDelChk: begin
        if (next_idx < cnt_q) begin
          ram_raddr = next_idx[IdxW-1:0];
          state_d   = StDelWr;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = StFin;
        end
      end

      StDelWr: begin
        ram_we  = 1'b1;
        idx_d   = next_idx;
        state_d = StDelChk;
      end

      StFin: begin
        valid_d  = 1'b1;
        ostat_d  = stat_q;
        otouch_d = TouchW'(at_q);
        ocount_d = CountW'(cnt_q);
        state_d  = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    stat_q   <= stat_d;
    q_q      <= q_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    idx_q    <= idx_d;
    at_q     <= at_d;
    best_q   <= best_d;
    step_q   <= step_d;
    seg_q    <= seg_d;
    have_q   <= have_d;
    lacc_q   <= lacc_d;
    cacc_q   <= cacc_d;
    t_q      <= t_d;
    cr_q     <= cr_d;
    lhs_q    <= lhs_d;
    bl_q     <= bl_d;
    bc_q     <= bc_d;
    ostat_q  <= ostat_d;
    otouch_q <= otouch_d;
    ocount_q <= ocount_d;
  end

  assign busy            = (state_q != StIdle);
  assign valid_o         = valid_q;
  assign status_o        = ostat_q;
  assign touched_index_o = otouch_q;
  assign point_count_o   = ocount_q;

  `PPE_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= CntW'(MaxPoints), "point count over table size")
  `PPE_ASSERT_NEXT(a_result_gap, valid_o, !valid_o, "results in consecutive cycles")
  `PPE_ASSERT_SAME(a_full_count, valid_o && status_o == StatFull,
                   point_count_o == CountW'(MaxPoints), "full status with room left")
  `PPE_ASSERT_SAME(a_empty_count, valid_o && status_o == StatEmpty,
                   point_count_o == '0 && touched_index_o == '0, "empty status with points")

endmodule

FILE: tb/sv/ppe_checker.sv
// checker for the polyline point editor: watches command and result transfers,
// predicts each result from its own copy of the path and compares field by field
// depends on ppe_pkg
`timescale 1ns / 1ps

module ppe_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         op_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic               valid_o,
  input  logic [1:0]         status_o,
  input  logic [5:0]         touched_index_o,
  input  logic [6:0]         point_count_o,
  output int                 fail_count,
  output int                 pending
);
  import ppe_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] touched;
    logic [6:0] count;
  } edit_result_t;

  typedef logic signed [31:0] crd_t;

  crd_t path_x [MaxPoints+1];
  crd_t path_y [MaxPoints+1];
  crd_t path_z [MaxPoints+1];
  int   held;
  edit_result_t result_q[$];

  assign pending = result_q.size();

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int closest_point(crd_t qx, crd_t qy, crd_t qz);
    int best;
    logic [63:0] bd, d;
    longint dx, dy, dz;
    best = 0;
    bd = '0;
    for (int i = 0; i < held; i++) begin
      dx = path_x[i] - qx; dy = path_y[i] - qy; dz = path_z[i] - qz;
      d = dx*dx + dy*dy + dz*dz;
      if (i == 0 || d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  // exact compare of |L x W|^2 / |L|^2 by cross multiplication
  function automatic int closest_segment(crd_t qx, crd_t qy, crd_t qz);
    int best;
    bit have;
    logic signed [63:0] lx, ly, lz, wx, wy, wz, cx, cy, cz;
    logic [191:0] bc, bl, c, l;
    best = held;
    have = 0;
    bc = '0;
    bl = '0;
    for (int i = 0; i + 1 < held; i++) begin
      lx = path_x[i+1] - path_x[i]; ly = path_y[i+1] - path_y[i];
      lz = path_z[i+1] - path_z[i];
      wx = path_x[i] - qx; wy = path_y[i] - qy; wz = path_z[i] - qz;
      l = 192'(lx*lx) + 192'(ly*ly) + 192'(lz*lz);
      if (l == 0) continue;
      cx = ly*wz - lz*wy; cy = lz*wx - lx*wz; cz = lx*wy - ly*wx;
      c = 192'(cx < 0 ? -cx : cx) * 192'(cx < 0 ? -cx : cx)
        + 192'(cy < 0 ? -cy : cy) * 192'(cy < 0 ? -cy : cy)
        + 192'(cz < 0 ? -cz : cz) * 192'(cz < 0 ? -cz : cz);
      if (!have || c * bl < bc * l) begin
        have = 1;
        bc = c;
        bl = l;
        best = i + 1;
      end
    end
    return best;
  endfunction

  function automatic edit_result_t apply_edit(logic [2:0] op, crd_t qx, crd_t qy, crd_t qz);
    edit_result_t r;
    int at;
    r = '0;
    at = 0;
    if (op == OpDelete || op == OpMove) begin
      if (held == 0) r.status = StatEmpty;
      else begin
        at = closest_point(qx, qy, qz);
        if (op == OpDelete) begin
          for (int i = at; i + 1 < held; i++) begin
            path_x[i] = path_x[i+1]; path_y[i] = path_y[i+1]; path_z[i] = path_z[i+1];
          end
          held--;
        end else begin
          path_x[at] = qx; path_y[at] = qy; path_z[at] = qz;
        end
      end
    end else if (op == OpPrepend || op == OpAppend || op == OpInsert) begin
      if (held >= MaxPoints) r.status = StatFull;
      else begin
        if (op == OpPrepend) at = 0;
        else if (op == OpAppend || held < 2) at = held;
        else at = closest_segment(qx, qy, qz);
        for (int i = held; i > at; i--) begin
          path_x[i] = path_x[i-1]; path_y[i] = path_y[i-1]; path_z[i] = path_z[i-1];
        end
        path_x[at] = qx; path_y[at] = qy; path_z[at] = qz;
        held++;
      end
    end
    r.touched = 6'(at);
    r.count = 7'(held);
    return r;
  endfunction

  edit_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held <= 0;
      fail_count <= 0;
    end else begin
      if (start && !busy)
        result_q.push_back(apply_edit(op_i, pos_x_i, pos_y_i, pos_z_i));
      if (valid_o) begin
        if (result_q.size() == 0) begin
          $display("result with nothing expected at %0t", $realtime);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (status_o !== want.status) report("status", status_o, want.status);
          if (touched_index_o !== want.touched)
            report("touched_index", touched_index_o, want.touched);
          if (point_count_o !== want.count)
            report("point_count", point_count_o, want.count);
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb_polyline_point_editor.sv
// testbench top for the polyline point editor: drives directed and random edits
// with random gaps and gives the verdict; depends on ppe_pkg, ppe_checker and the rtl
`timescale 1ns / 1ps

module tb_polyline_point_editor;
  import ppe_pkg::*;

  localparam int StallLimit = 200000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic [2:0] op_i = '0;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic valid_o;
  logic [1:0] status_o;
  logic [5:0] touched_index_o;
  logic [6:0] point_count_o;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm = 0;

  always #2 clk_i = ~clk_i;

  polyline_point_editor dut (.*);
  ppe_checker u_checker (.*);

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_polyline_point_editor: errors");
      $finish;
    end
  end

  // start stays high from one transfer into the next unless a gap is drawn
  task automatic edit(logic [2:0] op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if (!calm && $urandom_range(99) < 27) begin
      start <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < 27);
    end
    start <= 1; op_i <= op; pos_x_i <= x; pos_y_i <= y; pos_z_i <= z;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [15:0] coord_pick();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty table, extremes, zero-length segments, ties, unknown ops
    edit(OpDelete, 0, 0, 0);
    edit(OpMove, 16'h7fff, 0, 0);
    edit(OpInsert, 16'h8000, 16'h8000, 16'h8000);
    edit(OpInsert, 16'h7fff, 16'h7fff, 16'h7fff);
    edit(OpInsert, 0, 0, 0);
    edit(OpAppend, 0, 0, 0);
    edit(OpInsert, 5, 5, 5);
    edit(OpPrepend, 16'h8000, 16'h7fff, 16'h8000);
    edit(OpInsert, 16'h7fff, 16'h8000, 16'h7fff);
    edit(3'd5, 1, 2, 3);
    edit(3'd6, 16'hffff, 16'hffff, 16'hffff);
    edit(3'd7, 0, 0, 0);
    edit(OpMove, 0, 0, 0);
    edit(OpDelete, 16'h7fff, 16'h7fff, 16'h7fff);
    for (int i = 0; i < 6; i++) edit(OpDelete, 0, 0, 0);
    for (int i = 0; i < 3; i++) edit(OpAppend, 7, 7, 7);
    edit(OpInsert, 1, 2, 3);
    edit(OpDelete, 7, 7, 7);
    // fill to full, then overflow
    for (int i = 0; i < 62; i++) begin
      calm = (i > 20 && i < 50);
      edit(OpAppend, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    calm = 0;
    edit(OpPrepend, 1, 1, 1);
    edit(OpAppend, 1, 1, 1);
    edit(OpInsert, 1, 1, 1);
    for (int i = 0; i < 60; i++) edit(OpDelete, 16'($urandom), 16'($urandom), 16'($urandom));
    // random edits, weighted towards adding points
    for (int i = 0; i < 400; i++) begin
      calm = (i >= 200 && i < 280);
      case ($urandom_range(19))
        0, 1, 2, 3: op = OpDelete;
        4, 5, 6: op = OpMove;
        7, 8: op = OpPrepend;
        9, 10, 11: op = OpAppend;
        19: op = 3'($urandom_range(7, 5));
        default: op = OpInsert;
      endcase
      edit(op, coord_pick(), coord_pick(), coord_pick());
    end
    calm = 0;
    start <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("tb_polyline_point_editor: clean");
    else $display("tb_polyline_point_editor: errors");
    $finish;
  end
endmodule

FILE: polyline_point_editor.f
+incdir+rtl
rtl/ppe_pkg.sv
rtl/ppe_ram.sv
rtl/ppe_mul.sv
rtl/polyline_point_editor.sv
tb/sv/ppe_checker.sv
tb/sv/tb_polyline_point_editor.sv
